FILE: rtl/core/htt_pkg.sv
package htt_pkg;

    localparam int NUM_TIMERS_DEF = 32;
    localparam logic [31:0] LIMIT_RESET = 32'hFFFF_FFFF;

    typedef enum logic [1:0] {
        MODE_TICK   = 2'd0,
        MODE_ADD    = 2'd1,
        MODE_DELETE = 2'd2,
        MODE_NONE   = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        ST_OK           = 2'd0,
        ST_BAD_INTERVAL = 2'd1,
        ST_FULL         = 2'd2,
        ST_NOT_ARMED    = 2'd3
    } status_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [5:0]  slot_index;
        logic [31:0] interval;
        logic [31:0] repeat_count;
    } in_item_t;

    typedef struct packed {
        logic [5:0] slot_id;
        logic [1:0] status;
        logic       fired;
        logic       retired;
        logic       last;
    } out_item_t;

    // classified command from front to back
    typedef struct packed {
        mode_t       mode;
        status_t     status;
        logic [5:0]  slot;
        logic [31:0] interval;
        logic [31:0] repeat_count;
    } cmd_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_SCAN,
        BK_FLUSH
    } back_state_t;

endpackage

FILE: rtl/core/htt_ram.sv
module htt_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

FILE: rtl/core/htt_front.sv
module htt_front #(
    parameter int NUM_TIMERS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [31:0]       limit,
    input  htt_pkg::in_item_t item,
    input  logic              item_valid,
    output logic              item_ready,
    output htt_pkg::cmd_t     cmd,
    output logic              cmd_valid,
    input  logic              cmd_ready
);
    import htt_pkg::*;

    cmd_t cmd_reg, cmd_next;
    logic valid_reg;

    // front owns nothing but the skid register; busy is tracked in the back
    assign item_ready = !valid_reg;
    assign cmd = cmd_reg;
    assign cmd_valid = valid_reg;

    always_comb
    begin
        cmd_next = '0;
        cmd_next.mode = mode_t'(item.mode);
        cmd_next.slot = item.slot_index;
        cmd_next.interval = item.interval;
        cmd_next.repeat_count = item.repeat_count;
        cmd_next.status = ST_OK;
        if (item.mode == MODE_ADD)
        begin
            if (item.interval == 32'd0 || item.interval >= limit)
            begin
                cmd_next.status = ST_BAD_INTERVAL;
            end
        end
        else if (item.mode == MODE_DELETE)
        begin
            if ({26'd0, item.slot_index} >= 32'(NUM_TIMERS))
            begin
                cmd_next.status = ST_NOT_ARMED;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (item_valid && item_ready)
        begin
            valid_reg <= (item.mode != MODE_NONE);
        end
        else if (cmd_ready)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_valid && item_ready)
        begin
            cmd_reg <= cmd_next;
        end
    end
endmodule

FILE: rtl/core/htt_back.sv
module htt_back #(
    parameter int NUM_TIMERS = 32
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  htt_pkg::cmd_t         cmd,
    input  logic                  cmd_valid,
    output logic                  cmd_ready,
    output htt_pkg::out_item_t    res,
    output logic                  res_valid,
    input  logic                  res_ready
);
    import htt_pkg::*;

    localparam int AW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;

    back_state_t state_reg, state_next;
    logic [NUM_TIMERS-1:0] busy_reg;
    logic [31:0] time_reg;
    logic [AW-1:0] idx_reg;
    logic [AW:0] cnt_reg;
    logic pend_reg;
    out_item_t pend_item_reg;
    out_item_t res_reg;
    logic res_valid_reg;

    logic [31:0] dl_rd, per_rd, rem_rd;
    logic dl_we, rem_we;
    logic [31:0] dl_wd, rem_wd;
    logic [AW-1:0] wa, ra;
    logic per_we;

    htt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS), .AW(AW)) u_dl
        (.clk(clk), .we(dl_we), .waddr(wa), .wdata(dl_wd), .raddr(ra), .rdata(dl_rd));
    htt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS), .AW(AW)) u_per
        (.clk(clk), .we(per_we), .waddr(wa), .wdata(cmd.interval), .raddr(ra),
         .rdata(per_rd));
    htt_ram #(.WIDTH(32), .DEPTH(NUM_TIMERS), .AW(AW)) u_rem
        (.clk(clk), .we(rem_we), .waddr(wa), .wdata(rem_wd), .raddr(ra), .rdata(rem_rd));

    assign res = res_reg;
    assign res_valid = res_valid_reg;

    logic out_free;
    assign out_free = !res_valid_reg || res_ready;

    // lowest free slot
    logic [AW-1:0] free_idx;
    logic free_found;
    always_comb
    begin
        free_idx = '0;
        free_found = 1'b0;
        for (int i = NUM_TIMERS - 1; i >= 0; i--)
        begin
            if (!busy_reg[i])
            begin
                free_idx = AW'(i);
                free_found = 1'b1;
            end
        end
    end

    logic [AW-1:0] cur;
    assign cur = AW'(cnt_reg - 1'b1);
    logic hit;
    assign hit = (state_reg == BK_SCAN) && busy_reg[cur] && (dl_rd == time_reg);
    logic scan_done;
    assign scan_done = (cnt_reg == (AW+1)'(NUM_TIMERS));

    // a hit is taken when nothing is pending or the pending one can move out
    logic take_hit;
    assign take_hit = hit && (out_free || !pend_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (cmd_valid && out_free && !pend_reg && cmd.mode == MODE_TICK)
                begin
                    state_next = BK_READ;
                end
            end
            BK_READ: state_next = BK_SCAN;
            BK_SCAN:
            begin
                if ((!hit || take_hit) && scan_done)
                begin
                    state_next = BK_FLUSH;
                end
            end
            BK_FLUSH:
            begin
                if (out_free) state_next = BK_IDLE;
            end
            default: state_next = BK_IDLE;
        endcase
    end

    // scan advances when the current slot needs no output or its hit is taken;
    // the read address runs one ahead
    logic adv;
    assign adv = (state_reg == BK_READ) ||
                 ((state_reg == BK_SCAN) && (!hit || take_hit) && !scan_done);
    logic idle_cmd;
    assign idle_cmd = (state_reg == BK_IDLE) && cmd_valid && out_free && !pend_reg;

    logic res_load;
    assign res_load = (idle_cmd && cmd.mode != MODE_TICK) ||
                      (take_hit && pend_reg) ||
                      (state_reg == BK_FLUSH && out_free);

    logic [31:0] rem_dec;
    assign rem_dec = rem_rd - 32'd1;

    // outputs
    always_comb
    begin
        cmd_ready = 1'b0;
        dl_we = 1'b0;
        per_we = 1'b0;
        rem_we = 1'b0;
        wa = free_idx;
        dl_wd = time_reg + cmd.interval;
        rem_wd = cmd.repeat_count;
        ra = idx_reg;
        unique case (state_reg)
            BK_IDLE:
            begin
                if (idle_cmd)
                begin
                    cmd_ready = (cmd.mode != MODE_TICK);
                    if (cmd.mode == MODE_ADD && cmd.status == ST_OK && free_found)
                    begin
                        dl_we = 1'b1;
                        per_we = 1'b1;
                        rem_we = 1'b1;
                    end
                end
                ra = '0;
            end
            BK_READ: ra = idx_reg;
            BK_SCAN:
            begin
                wa = cur;
                dl_wd = time_reg + per_rd;
                rem_wd = rem_dec;
                if (take_hit)
                begin
                    dl_we = 1'b1;
                    rem_we = (rem_rd != 32'd0);
                end
                // hold the read on the current slot while stalled
                ra = adv ? idx_reg : cur;
            end
            BK_FLUSH: cmd_ready = out_free;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= BK_IDLE;
            busy_reg <= '0;
            time_reg <= '0;
            idx_reg <= '0;
            cnt_reg <= '0;
            pend_reg <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (res_load)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (res_ready)
            begin
                res_valid_reg <= 1'b0;
            end
            if (idle_cmd)
            begin
                unique case (cmd.mode)
                    MODE_TICK:
                    begin
                        time_reg <= time_reg + 32'd1;
                        idx_reg <= '0;
                        cnt_reg <= '0;
                    end
                    MODE_ADD:
                    begin
                        if (cmd.status == ST_OK && free_found)
                        begin
                            busy_reg[free_idx] <= 1'b1;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (cmd.status == ST_OK && busy_reg[cmd.slot[AW-1:0]])
                        begin
                            busy_reg[cmd.slot[AW-1:0]] <= 1'b0;
                        end
                    end
                    default: ;
                endcase
            end
            if (adv)
            begin
                idx_reg <= (idx_reg == AW'(NUM_TIMERS - 1)) ? idx_reg : idx_reg + 1'b1;
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (take_hit)
            begin
                pend_reg <= 1'b1;
                if (rem_rd == 32'd1) busy_reg[cur] <= 1'b0;
            end
            else if (state_reg == BK_FLUSH && out_free)
            begin
                // drop the pending hit into the output with last set
                pend_reg <= 1'b0;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (idle_cmd && cmd.mode == MODE_ADD)
        begin
            res_reg <= '{slot_id: (cmd.status == ST_OK && free_found) ?
                             6'(free_idx) : 6'd0,
                         status: (cmd.status != ST_OK) ? cmd.status :
                             (free_found ? ST_OK : ST_FULL),
                         fired: 1'b0, retired: 1'b0, last: 1'b1};
        end
        else if (idle_cmd && cmd.mode == MODE_DELETE)
        begin
            res_reg <= '{slot_id: cmd.slot,
                         status: (cmd.status == ST_OK && busy_reg[cmd.slot[AW-1:0]]) ?
                             ST_OK : ST_NOT_ARMED,
                         fired: 1'b0, retired: 1'b0, last: 1'b1};
        end
        else if (take_hit && pend_reg)
        begin
            res_reg <= pend_item_reg;
        end
        else if (state_reg == BK_FLUSH && out_free)
        begin
            if (pend_reg)
            begin
                res_reg <= '{slot_id: pend_item_reg.slot_id, status: ST_OK,
                             fired: 1'b1, retired: pend_item_reg.retired, last: 1'b1};
            end
            else
            begin
                res_reg <= '{slot_id: 6'd0, status: ST_OK, fired: 1'b0,
                             retired: 1'b0, last: 1'b1};
            end
        end
        if (take_hit)
        begin
            pend_item_reg <= '{slot_id: 6'(cur), status: ST_OK, fired: 1'b1,
                               retired: (rem_rd == 32'd1), last: 1'b0};
        end
    end
endmodule

FILE: rtl/core/hierarchical_timer_table.sv
// Channel  | Direction | Handshake          | Payload
// in       | sink      | in_valid/in_ready  | htt_pkg::in_item_t
// out      | source    | out_valid/out_ready| htt_pkg::out_item_t
// cfg      | sink      | cfg_we             | interval_limit (32 bit)
//
// Add and delete results pass through the front skid and back result registers.
// A tick steps the back end through read, scan and flush; it reads the slot
// tables one entry a cycle through one shared read address, unless out stalls.
// Reset clears time and busy flags and sets the limit to all ones; the slot
// tables need no clearing. A held result stalls the scan once a second expiry
// waits behind it; the front skid holds one item.
module hierarchical_timer_table
    import htt_pkg::*;
#(
    parameter int NUM_TIMERS = htt_pkg::NUM_TIMERS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [31:0]        cfg_data,
    input  htt_pkg::in_item_t  in_data,
    input  logic               in_valid,
    output logic               in_ready,
    output htt_pkg::out_item_t out_data,
    output logic               out_valid,
    input  logic               out_ready
);
    logic [31:0] limit_reg;
    cmd_t cmd;
    logic cmd_valid, cmd_ready;

    // hold the interval limit
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg_we)
        begin
            limit_reg <= cfg_data;
        end
    end

    // front: classify each transaction
    htt_front #(.NUM_TIMERS(NUM_TIMERS)) u_front (
        .clk(clk), .rst_n(rst_n), .limit(limit_reg),
        .item(in_data), .item_valid(in_valid), .item_ready(in_ready),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready)
    );

    // back: carry out ticks, adds and deletes
    htt_back #(.NUM_TIMERS(NUM_TIMERS)) u_back (
        .clk(clk), .rst_n(rst_n), .cmd(cmd), .cmd_valid(cmd_valid),
        .cmd_ready(cmd_ready), .res(out_data),
        .res_valid(out_valid), .res_ready(out_ready)
    );

    a_fired_ok: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.fired |-> out_data.status == ST_OK)
        else $error("fired result with bad status");
    a_retire_fired: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.retired |-> out_data.fired)
        else $error("retired without fire");
    a_reply_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.fired |-> out_data.last)
        else $error("reply without last");
endmodule
